// ===== hdl/gregorian_date_counter_macros.svh =====
// Assertion macros used by the date counter top level.
// Needs signals clk and arst_n in the scope of the macro use.
`ifndef GREGORIAN_DATE_COUNTER_MACROS_SVH
`define GREGORIAN_DATE_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define GDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gdc_pkg.sv =====
// Shared types, constants and calendar functions for the date counter.
// No dependencies; used by gdc_next_date and gregorian_date_counter.
`timescale 1ns / 1ps

package gdc_pkg;

	// operation codes carried on s_tuser
	typedef enum logic [2:0] {
		MODE_LOAD       = 3'd0,
		MODE_NEXT_DAY   = 3'd1,
		MODE_PREV_DAY   = 3'd2,
		MODE_NEXT_MONTH = 3'd3,
		MODE_PREV_MONTH = 3'd4,
		MODE_SHIFT_YEAR = 3'd5
	} mode_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_t;

	localparam logic [13:0] YEAR_MIN   = 14'd1;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;
	localparam logic [4:0]  DAY_FIRST  = 5'd1;
	localparam logic [4:0]  DAY_MAX    = 5'd31;

	// 25 is odd: n divisible by 25 iff n * inv(25) mod 2^14 <= (2^14 - 1) / 25
	localparam logic [13:0] INV25       = 14'd7209;
	localparam logic [13:0] DIV25_LIMIT = 14'd655;

	// floor(n / 100) = (n * 5243) >> 19, exact for n < 43690
	localparam logic [12:0] RECIP100       = 13'd5243;
	localparam int          RECIP100_SHIFT = 19;

	// leap: divisible by 4, and not by 25 unless also by 16 (400 = 16 * 25)
	function automatic logic is_leap(input logic [13:0] y);
		logic [13:0] prod;
		logic        div25;
		prod  = 14'(y * INV25);
		div25 = (prod <= DIV25_LIMIT);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	// days in a month; zero for a month code outside 1..12
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the months before m of a common year
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// floor(31 * mm / 12) with March as mm = 1 and February as mm = 12
	function automatic logic [4:0] month_term(input logic [3:0] m);
		logic [4:0] t;
		case (m)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== hdl/gdc_next_date.sv =====
// Next-date logic: applies one operation to the held date.
// Depends on gdc_pkg (date_t, mode_t, calendar functions).
`timescale 1ns / 1ps

module gdc_next_date (
	input  gdc_pkg::date_t     cur,
	input  logic [2:0]         mode,
	input  logic [4:0]         load_day,
	input  logic [3:0]         load_month,
	input  logic [13:0]        load_year,
	input  logic signed [14:0] year_delta,
	output gdc_pkg::date_t     nxt,
	output logic               sat
);

	logic               leap_cur;
	logic [4:0]         len_cur;
	logic [3:0]         month_inc;
	logic [3:0]         month_dec;
	logic [4:0]         len_inc;
	logic [4:0]         len_dec;
	logic signed [15:0] shift_sum;
	logic [13:0]        shift_year;
	logic               shift_sat;
	logic [4:0]         len_shift;

	// month lengths around the held date
	assign leap_cur  = gdc_pkg::is_leap(cur.year);
	assign len_cur   = gdc_pkg::month_len(cur.month, leap_cur);
	assign month_inc = cur.month + 4'd1;
	assign month_dec = cur.month - 4'd1;
	assign len_inc   = gdc_pkg::month_len(month_inc, leap_cur);
	assign len_dec   = gdc_pkg::month_len(month_dec, leap_cur);

	// year shift with saturation at both ends
	assign shift_sum = $signed({2'b00, cur.year}) + {year_delta[14], year_delta};

	always_comb begin
		shift_sat  = 1'b0;
		shift_year = shift_sum[13:0];
		if (shift_sum < $signed({2'b00, gdc_pkg::YEAR_MIN})) begin
			shift_year = gdc_pkg::YEAR_MIN;
			shift_sat  = 1'b1;
		end else if (shift_sum > $signed({2'b00, gdc_pkg::YEAR_MAX})) begin
			shift_year = gdc_pkg::YEAR_MAX;
			shift_sat  = 1'b1;
		end
	end

	assign len_shift = gdc_pkg::month_len(cur.month, gdc_pkg::is_leap(shift_year));

	// operation decode
	always_comb begin
		nxt = cur;
		sat = 1'b0;
		unique case (gdc_pkg::mode_t'(mode))
			gdc_pkg::MODE_LOAD: begin
				nxt.day = (load_day == 5'd0) ? gdc_pkg::DAY_FIRST : load_day;
				if (load_month == 4'd0) begin
					nxt.month = gdc_pkg::MONTH_JAN;
				end else if (load_month > gdc_pkg::MONTH_DEC) begin
					nxt.month = gdc_pkg::MONTH_DEC;
				end else begin
					nxt.month = load_month;
				end
				if (load_year < gdc_pkg::YEAR_MIN) begin
					nxt.year = gdc_pkg::YEAR_MIN;
					sat      = 1'b1;
				end else if (load_year > gdc_pkg::YEAR_MAX) begin
					nxt.year = gdc_pkg::YEAR_MAX;
					sat      = 1'b1;
				end else begin
					nxt.year = load_year;
				end
			end
			gdc_pkg::MODE_NEXT_DAY: begin
				if (cur.day >= len_cur) begin
					if (cur.month == gdc_pkg::MONTH_DEC) begin
						if (cur.year >= gdc_pkg::YEAR_MAX) begin
							sat = 1'b1;
						end else begin
							nxt.year  = cur.year + 14'd1;
							nxt.month = gdc_pkg::MONTH_JAN;
							nxt.day   = gdc_pkg::DAY_FIRST;
						end
					end else begin
						nxt.month = month_inc;
						nxt.day   = gdc_pkg::DAY_FIRST;
					end
				end else begin
					nxt.day = cur.day + 5'd1;
				end
			end
			gdc_pkg::MODE_PREV_DAY: begin
				if (cur.day <= gdc_pkg::DAY_FIRST) begin
					if (cur.month == gdc_pkg::MONTH_JAN) begin
						if (cur.year <= gdc_pkg::YEAR_MIN) begin
							sat = 1'b1;
						end else begin
							nxt.year  = cur.year - 14'd1;
							nxt.month = gdc_pkg::MONTH_DEC;
							nxt.day   = gdc_pkg::DAY_MAX;
						end
					end else begin
						nxt.month = month_dec;
						nxt.day   = len_dec;
					end
				end else begin
					nxt.day = cur.day - 5'd1;
				end
			end
			gdc_pkg::MODE_NEXT_MONTH: begin
				// into January the clamp is to 31, which never bites
				if (cur.month == gdc_pkg::MONTH_DEC) begin
					if (cur.year >= gdc_pkg::YEAR_MAX) begin
						sat = 1'b1;
					end else begin
						nxt.year  = cur.year + 14'd1;
						nxt.month = gdc_pkg::MONTH_JAN;
					end
				end else begin
					nxt.month = month_inc;
					if (cur.day > len_inc) begin
						nxt.day = len_inc;
					end
				end
			end
			gdc_pkg::MODE_PREV_MONTH: begin
				if (cur.month == gdc_pkg::MONTH_JAN) begin
					if (cur.year <= gdc_pkg::YEAR_MIN) begin
						sat = 1'b1;
					end else begin
						nxt.year  = cur.year - 14'd1;
						nxt.month = gdc_pkg::MONTH_DEC;
					end
				end else begin
					nxt.month = month_dec;
					if (cur.day > len_dec) begin
						nxt.day = len_dec;
					end
				end
			end
			gdc_pkg::MODE_SHIFT_YEAR: begin
				nxt.year = shift_year;
				sat      = shift_sat;
				if (cur.day > len_shift) begin
					nxt.day = len_shift;
				end
			end
			default: begin
				nxt = cur;
				sat = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/gregorian_date_counter.sv =====
// Gregorian date counter, top level. Depends on gdc_pkg, gdc_next_date and
// gregorian_date_counter_macros.svh.
//
// Input beats (s_tvalid/s_tready) carry an operation in s_tuser and its
// operands in s_tdata; each beat updates the held date and yields exactly
// one output beat (m_tvalid/m_tready) with the new date, weekday, day of
// year and status flags.
// Throughput: one beat per cycle while m_tready is high. The held date is
// updated at the accepting edge, so consecutive beats chain with no gap.
// The result reaches m_tvalid through stage 1, which holds the new date, and
// three registered stages that compute the leap test and the divide by 100,
// the weekday sum, and the mod-7 fold with the flags.
// Reset (arst_n low) empties the pipeline and sets the date to 1 January 2000.
// When the receiver holds m_tready low the stages fill up and s_tready drops
// once all are full; nothing is dropped and the output beat holds steady.
`timescale 1ns / 1ps
`include "gregorian_date_counter_macros.svh"

module gregorian_date_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] load_day, [8:5] load_month, [22:9] load_year,
	// [37:23] year_delta (signed), [39:38] zero
	input  logic [39:0] s_tdata,
	// [2:0] mode
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] out_day, [8:5] out_month, [22:9] out_year, [25:23] weekday,
	// [34:26] day_of_year, [35] leap_year, [36] last_day_of_month,
	// [37] date_valid, [38] year_saturated, [39] zero
	output logic [39:0] m_tdata
);

	gdc_pkg::date_t cur_q;
	gdc_pkg::date_t nxt_date;
	logic           nxt_sat;
	logic           s_accept;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	gdc_pkg::date_t date_s1, date_s2, date_s3;
	logic           sat_s1, sat_s2, sat_s3;
	logic           leap_s2, leap_s3;
	logic [13:0]    yy_s2;
	logic [6:0]     q100_s2;
	logic [13:0]    wsum_s3;
	logic [8:0]     doy_s3;
	logic [39:0]    data_s4;

	logic [13:0]    yy_s1;
	logic [26:0]    q100_prod;
	logic [14:0]    wsum;
	logic [8:0]     doy;
	logic [5:0]     fold1;
	logic [3:0]     fold2;
	logic [2:0]     wday;
	logic [4:0]     len_s3;
	logic [39:0]    data_next;

	// stage readiness, back from the output register
	assign rdy_s4   = !valid_s4 || m_tready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign s_accept = s_tvalid && s_tready;

	// date update for the incoming beat
	gdc_next_date u_next (
		.cur        (cur_q),
		.mode       (s_tuser),
		.load_day   (s_tdata[4:0]),
		.load_month (s_tdata[8:5]),
		.load_year  (s_tdata[22:9]),
		.year_delta ($signed(s_tdata[37:23])),
		.nxt        (nxt_date),
		.sat        (nxt_sat)
	);

	// held date and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.day   <= gdc_pkg::DAY_FIRST;
			cur_q.month <= gdc_pkg::MONTH_JAN;
			cur_q.year  <= 14'd2000;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
		end else begin
			if (s_accept) begin
				cur_q <= nxt_date;
			end
			if (rdy_s1) begin
				valid_s1 <= s_accept;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// stage 2 inputs: weekday year (Jan/Feb count in the year before), /100
	assign yy_s1     = date_s1.year - {13'd0, (date_s1.month <= gdc_pkg::MONTH_FEB)};
	assign q100_prod = 27'(yy_s1) * 27'(gdc_pkg::RECIP100);

	// stage 3 inputs: weekday sum and ordinal day
	assign wsum = 15'(date_s2.day) + 15'(yy_s2) + 15'(yy_s2[13:2]) - 15'(q100_s2)
		+ 15'(q100_s2[6:2]) + 15'(gdc_pkg::month_term(date_s2.month));
	assign doy  = gdc_pkg::days_before(date_s2.month)
		+ 9'((date_s2.month > gdc_pkg::MONTH_FEB) && leap_s2) + 9'(date_s2.day);

	// stage 4 inputs: mod 7 by folding octal digits (8 = 1 mod 7), then flags
	always_comb begin
		fold1 = 6'(wsum_s3[2:0]) + 6'(wsum_s3[5:3]) + 6'(wsum_s3[8:6])
			+ 6'(wsum_s3[11:9]) + 6'(wsum_s3[13:12]);
		fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
		wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
	end

	assign len_s3    = gdc_pkg::month_len(date_s3.month, leap_s3);
	assign data_next = {1'b0, sat_s3, (date_s3.day <= len_s3), (date_s3.day == len_s3),
		leap_s3, doy_s3, wday, date_s3.year, date_s3.month, date_s3.day};

	// pipeline payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			date_s1 <= nxt_date;
			sat_s1  <= nxt_sat;
		end
		if (rdy_s2) begin
			date_s2 <= date_s1;
			sat_s2  <= sat_s1;
			leap_s2 <= gdc_pkg::is_leap(date_s1.year);
			yy_s2   <= yy_s1;
			q100_s2 <= 7'(q100_prod >> gdc_pkg::RECIP100_SHIFT);
		end
		if (rdy_s3) begin
			date_s3 <= date_s2;
			sat_s3  <= sat_s2;
			leap_s3 <= leap_s2;
			wsum_s3 <= wsum[13:0];
			doy_s3  <= doy;
		end
		if (rdy_s4) begin
			data_s4 <= data_next;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = data_s4;

	// checks
	`GDC_ASSERT_NOW(a_month_range, 1'b1, (cur_q.month >= gdc_pkg::MONTH_JAN) && (cur_q.month <= gdc_pkg::MONTH_DEC), "held month out of range")
	`GDC_ASSERT_NOW(a_year_range, 1'b1, (cur_q.year >= gdc_pkg::YEAR_MIN) && (cur_q.year <= gdc_pkg::YEAR_MAX), "held year out of range")
	`GDC_ASSERT_NEXT(a_accept_fills_s1, s_accept, valid_s1 && (date_s1 == cur_q), "accepted beat not in stage 1")
	`GDC_ASSERT_NOW(a_sat_at_limit, valid_s1 && sat_s1, (date_s1.year == gdc_pkg::YEAR_MIN) || (date_s1.year == gdc_pkg::YEAR_MAX), "saturation away from a year limit")
	`GDC_ASSERT_NEXT(a_load_day, s_accept && (s_tuser == gdc_pkg::MODE_LOAD) && (s_tdata[4:0] != 5'd0), cur_q.day == $past(s_tdata[4:0]), "loaded day not stored")

endmodule
